FILE: hdl/sic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sic_pkg
// Types, codes and fixed coefficients for the sea ice concentration pipeline.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int FRAC_BITS_DEF = 24;

  localparam int TB_W   = 16;
  localparam int CONC_W = 11;
  localparam int STAT_W = 3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
  localparam logic [STAT_W-1:0] ST_CROP = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIGH = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD  = 3'd4;
  localparam logic [STAT_W-1:0] ST_ZDIV = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEMI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT  = 1'b1;
  localparam logic [7:0] SAT_RESET = 8'd8;

  // satellite number folding and the ids that get the linear correction
  localparam logic signed [9:0] SAT_WRAP   = 10'sd20;
  localparam logic signed [9:0] SAT_OFFSET = 10'sd233;
  localparam logic signed [9:0] SAT_F11    = 10'sd11;
  localparam logic signed [9:0] SAT_F13    = 10'sd13;
  localparam logic signed [9:0] SAT_F14    = 10'sd14;
  localparam logic signed [9:0] SAT_F15    = 10'sd15;

  // corrected temperatures in 1e-5 K
  localparam int XW = 28;
  localparam logic signed [XW-1:0] PASS_GAIN = 28'sd1000;
  localparam logic signed [XW-1:0] G19H_GAIN = 28'sd1013;
  localparam logic signed [XW-1:0] G19H_OFS  = -28'sd189000;
  localparam logic signed [XW-1:0] G19V_GAIN = 28'sd1013;
  localparam logic signed [XW-1:0] G19V_OFS  = -28'sd251000;
  localparam logic signed [XW-1:0] G37V_GAIN = 28'sd1000;
  localparam logic signed [XW-1:0] G37V_OFS  = 28'sd5200;

  // final scaling: concentration in 1/16 percent
  localparam int CONC_SCALE = 1600;
  localparam int LOW_DIV    = 5;    // total < -20 <=> 5*|N| > D
  localparam int HIGH_NUM   = 100;  // total > 127 <=> 100*N > 127*D
  localparam int HIGH_DEN   = 127;

  localparam int COEF_W = 32;
  localparam int CF_A = 0, CF_B = 1, CF_C = 2, CF_D = 3;
  localparam int CF_E = 4, CF_F = 5, CF_G = 6, CF_H = 7;
  localparam int CF_N = 8;

  // [hemisphere][open water, first year, multiyear][19H, 19V, 37V], 0.1 K
  localparam longint TIE_PTS [2][3][3] = '{
    '{ '{1008, 1771, 2017}, '{2428, 2582, 2528}, '{2039, 2232, 1863} },
    '{ '{1003, 1766, 2005}, '{2378, 2498, 2433}, '{1937, 2216, 1903} }
  };

  function automatic longint sic_coef(input int hemi, input int idx);
    longint dw0, df0, dm0, sw0, sf0, sm0, dw1, df1, dm1, sw1, sf1, sm1;
    longint res;
    dw0 = TIE_PTS[hemi][0][1] - TIE_PTS[hemi][0][0];
    df0 = TIE_PTS[hemi][1][1] - TIE_PTS[hemi][1][0];
    dm0 = TIE_PTS[hemi][2][1] - TIE_PTS[hemi][2][0];
    sw0 = TIE_PTS[hemi][0][1] + TIE_PTS[hemi][0][0];
    sf0 = TIE_PTS[hemi][1][1] + TIE_PTS[hemi][1][0];
    sm0 = TIE_PTS[hemi][2][1] + TIE_PTS[hemi][2][0];
    dw1 = TIE_PTS[hemi][0][2] - TIE_PTS[hemi][0][1];
    df1 = TIE_PTS[hemi][1][2] - TIE_PTS[hemi][1][1];
    dm1 = TIE_PTS[hemi][2][2] - TIE_PTS[hemi][2][1];
    sw1 = TIE_PTS[hemi][0][2] + TIE_PTS[hemi][0][1];
    sf1 = TIE_PTS[hemi][1][2] + TIE_PTS[hemi][1][1];
    sm1 = TIE_PTS[hemi][2][2] + TIE_PTS[hemi][2][1];
    case (idx)
      CF_A:    res = (dm0 * dw1 - dm1 * dw0) + (df1 * dw0 - df0 * dw1);
      CF_B:    res = (dm1 * sw0 - dw1 * sm0) + (dw1 * sf0 - df1 * sw0);
      CF_C:    res = (dw0 * sm1 - dm0 * sw1) + (sw1 * df0 - dw0 * sf1);
      CF_D:    res = (sm0 * sw1 - sm1 * sw0) + (sf1 * sw0 - sf0 * sw1);
      CF_E:    res = df0 * (dm1 - dw1) + dw0 * (df1 - dm1) + dm0 * (dw1 - df1);
      CF_F:    res = df1 * (sm0 - sw0) + dw1 * (sf0 - sm0) + dm1 * (sw0 - sf0);
      CF_G:    res = df0 * (sw1 - sm1) + dw0 * (sm1 - sf1) + dm0 * (sf1 - sw1);
      CF_H:    res = sf1 * (sw0 - sm0) + sw1 * (sm0 - sf0) + sm1 * (sf0 - sw0);
      default: res = 0;
    endcase
    return res;
  endfunction

  function automatic logic sic_sat_corrected(input logic [7:0] id);
    logic signed [9:0] ts;
    logic              hit;
    ts = $signed({2'b00, id});
    if (ts > SAT_WRAP) ts = ts - SAT_OFFSET;
    case (ts) inside
      SAT_F11, SAT_F13, SAT_F14, SAT_F15: hit = 1'b1;
      default:                            hit = 1'b0;
    endcase
    return hit;
  endfunction

  typedef struct packed {
    logic [TB_W-1:0] tb19_vert;
    logic [TB_W-1:0] tb19_horiz;
    logic [TB_W-1:0] tb22_vert;
    logic [TB_W-1:0] tb37_vert;
    logic [TB_W-1:0] tb37_horiz;
  } sic_in_t;

  typedef struct packed {
    logic [CONC_W-1:0] concentration;
    logic [STAT_W-1:0] status;
  } sic_out_t;

endpackage
`default_nettype wire

FILE: hdl/sea_ice_concentration_team.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sea_ice_concentration_team
// Team rational-function sea ice concentration, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel of five brightness temperatures per clock while in_stall is
// low and returns one concentration/status beat per pixel, in order. The
// pipeline uses two restoring dividers for the polarization and gradient
// ratios (one quotient bit per stage, FRAC_BITS + 1 stages) and an 11-stage
// divider that forms the concentration. The whole pipeline holds while
// out_stall is high with a beat waiting; in_stall follows from that.
// hemisphere and satellite_id are meant to be written only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module sea_ice_concentration_team #(
  parameter int FRAC_BITS = sic_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire sic_pkg::sic_in_t                in_data,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      sic_pkg::sic_out_t               out_data,
  input  wire logic                            cfg_we,
  input  wire logic [sic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sic_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import sic_pkg::*;

  localparam int AW   = XW + 1;            // ratio operand magnitude
  localparam int RW   = AW + 1;            // divider remainder
  localparam int QW   = FRAC_BITS + 1;     // ratio quotient bits
  localparam int MW   = FRAC_BITS + 2;     // ratio magnitude incl. saturation
  localparam int VW   = MW + 1;            // signed ratio
  localparam int PGW  = FRAC_BITS + 4;     // signed ratio product
  localparam int PW   = COEF_W + PGW;      // coefficient products
  localparam int NW   = PW + 2;            // N and D
  localparam int RMW  = NW + 11;           // final remainder
  localparam int FQ   = CONC_W;            // final quotient bits

  // ---------------- configuration ----------------
  logic       hemi_r;
  logic [7:0] sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hemi_r <= 1'b0;
      sat_r  <= SAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEMI: hemi_r <= cfg_data[0];
        REG_SAT:  sat_r  <= cfg_data;
        default:  ;
      endcase
    end
  end

  logic corr;
  assign corr = sic_sat_corrected(sat_r);

  logic signed [COEF_W-1:0] coef [CF_N];
  for (genvar g = 0; g < CF_N; g++) begin : g_coef
    localparam logic signed [COEF_W-1:0] C_N = COEF_W'(sic_coef(0, g));
    localparam logic signed [COEF_W-1:0] C_S = COEF_W'(sic_coef(1, g));
    assign coef[g] = hemi_r ? C_S : C_N;
  end

  // ---------------- flow control ----------------
  logic     adv;
  logic     out_valid_r;
  sic_out_t out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- stage types ----------------
  typedef struct packed {
    logic                 vld;
    logic [STAT_W-1:0]    err;
    logic signed [XW-1:0] x19h;
    logic signed [XW-1:0] x19v;
    logic signed [XW-1:0] x37v;
  } s1_t;

  typedef struct packed {
    logic              vld;
    logic [STAT_W-1:0] err;
    logic [RW-1:0]     r_p;
    logic [RW-1:0]     r_g;
    logic [AW-1:0]     ad_p;
    logic [AW-1:0]     ad_g;
    logic [QW-1:0]     q_p;
    logic [QW-1:0]     q_g;
    logic              neg_p;
    logic              neg_g;
    logic              sat_p;
    logic              sat_g;
  } div_t;

  typedef struct packed {
    logic                 vld;
    logic [STAT_W-1:0]    err;
    logic signed [VW-1:0] pol;
    logic signed [VW-1:0] grd;
    logic [MW-1:0]        mag_p;
    logic [MW-1:0]        mag_g;
    logic                 pgneg;
  } rt_t;

  typedef struct packed {
    logic                 vld;
    logic [STAT_W-1:0]    err;
    logic signed [VW-1:0] pol;
    logic signed [VW-1:0] grd;
    logic [2*MW-1:0]      prod;
    logic                 pgneg;
  } ml_t;

  typedef struct packed {
    logic                  vld;
    logic [STAT_W-1:0]     err;
    logic signed [VW-1:0]  pol;
    logic signed [VW-1:0]  grd;
    logic signed [PGW-1:0] pg;
  } pg_t;

  typedef struct packed {
    logic              vld;
    logic [STAT_W-1:0] err;
    logic [CF_N-1:0][PW-1:0] p;
  } pr_t;

  typedef struct packed {
    logic                 vld;
    logic [STAT_W-1:0]    err;
    logic signed [NW-1:0] num;
    logic signed [NW-1:0] den;
  } nd_t;

  typedef struct packed {
    logic              vld;
    logic [STAT_W-1:0] err;
    logic              nneg;
    logic [NW-1:0]     nmag;
    logic [NW-1:0]     dmag;
  } mg_t;

  typedef struct packed {
    logic              vld;
    logic [STAT_W-1:0] st;
    logic [RMW-1:0]    rem;
    logic [NW-1:0]     d;
    logic [FQ-1:0]     q;
  } fd_t;

  s1_t  s1_r, s1_nxt;
  div_t dv_r [QW+1];
  div_t dv0_nxt;
  rt_t  s3_r, s3_nxt;
  ml_t  s4_r, s4_nxt;
  pg_t  s5_r, s5_nxt;
  pr_t  s6_r, s6_nxt;
  nd_t  s7_r, s7_nxt;
  mg_t  s8_r, s8_nxt;
  fd_t  fd_r [FQ+1];
  fd_t  fd0_nxt;

  // ---------------- stage 1: screening and intercalibration ----------------
  logic signed [XW-1:0] t19h, t19v, t37v;
  assign t19h = $signed(XW'(in_data.tb19_horiz));
  assign t19v = $signed(XW'(in_data.tb19_vert));
  assign t37v = $signed(XW'(in_data.tb37_vert));

  always_comb begin
    s1_nxt.vld = in_valid;
    // a channel sum of zero means both raw channels are zero
    if ((in_data.tb22_vert == '0 && in_data.tb19_vert == '0) ||
        (in_data.tb19_vert == '0 && in_data.tb19_horiz == '0) ||
        (in_data.tb37_vert == '0 && in_data.tb19_vert == '0)) begin
      s1_nxt.err = ST_BAD;
    end else begin
      s1_nxt.err = ST_OK;
    end
    if (corr) begin
      s1_nxt.x19h = t19h * G19H_GAIN + G19H_OFS;
      s1_nxt.x19v = t19v * G19V_GAIN + G19V_OFS;
      s1_nxt.x37v = t37v * G37V_GAIN + G37V_OFS;
    end else begin
      s1_nxt.x19h = t19h * PASS_GAIN;
      s1_nxt.x19v = t19v * PASS_GAIN;
      s1_nxt.x37v = t37v * PASS_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r <= '0;
    else if (adv) s1_r <= s1_nxt;
  end

  // ---------------- stage 2: ratio operands ----------------
  logic signed [AW-1:0] dp, sp, dg, sg;
  logic [AW-1:0]        an_p, ad_p, an_g, ad_g;

  assign dp = AW'(s1_r.x19v) - AW'(s1_r.x19h);
  assign sp = AW'(s1_r.x19v) + AW'(s1_r.x19h);
  assign dg = AW'(s1_r.x37v) - AW'(s1_r.x19v);
  assign sg = AW'(s1_r.x37v) + AW'(s1_r.x19v);
  assign an_p = dp[AW-1] ? AW'(-dp) : AW'(dp);
  assign ad_p = sp[AW-1] ? AW'(-sp) : AW'(sp);
  assign an_g = dg[AW-1] ? AW'(-dg) : AW'(dg);
  assign ad_g = sg[AW-1] ? AW'(-sg) : AW'(sg);

  always_comb begin
    dv0_nxt       = '0;
    dv0_nxt.vld   = s1_r.vld;
    dv0_nxt.err   = s1_r.err;
    if (s1_r.err == ST_OK && (ad_p == '0 || ad_g == '0)) dv0_nxt.err = ST_ZDIV;
    dv0_nxt.r_p   = RW'(an_p);
    dv0_nxt.r_g   = RW'(an_g);
    dv0_nxt.ad_p  = ad_p;
    dv0_nxt.ad_g  = ad_g;
    dv0_nxt.neg_p = dp[AW-1] ^ sp[AW-1];
    dv0_nxt.neg_g = dg[AW-1] ^ sg[AW-1];
    dv0_nxt.sat_p = {1'b0, an_p} >= {ad_p, 1'b0};
    dv0_nxt.sat_g = {1'b0, an_g} >= {ad_g, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= '0;
    else if (adv) dv_r[0] <= dv0_nxt;
  end

  // ---------------- ratio dividers: one quotient bit per stage ----------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    div_t          dv_nxt;
    logic [RW-1:0] rp, rg;

    // unless the ratio saturates, the remainder stays below the divisor, so the shift never overflows
    assign rp = (k == 0) ? dv_r[k].r_p : (dv_r[k].r_p << 1);
    assign rg = (k == 0) ? dv_r[k].r_g : (dv_r[k].r_g << 1);

    always_comb begin
      dv_nxt = dv_r[k];
      if (rp >= RW'(dv_r[k].ad_p)) begin
        dv_nxt.r_p = rp - RW'(dv_r[k].ad_p);
        dv_nxt.q_p = {dv_r[k].q_p[QW-2:0], 1'b1};
      end else begin
        dv_nxt.r_p = rp;
        dv_nxt.q_p = {dv_r[k].q_p[QW-2:0], 1'b0};
      end
      if (rg >= RW'(dv_r[k].ad_g)) begin
        dv_nxt.r_g = rg - RW'(dv_r[k].ad_g);
        dv_nxt.q_g = {dv_r[k].q_g[QW-2:0], 1'b1};
      end else begin
        dv_nxt.r_g = rg;
        dv_nxt.q_g = {dv_r[k].q_g[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= '0;
      else if (adv) dv_r[k+1] <= dv_nxt;
    end
  end

  // ---------------- stage 3: signed, saturated ratios ----------------
  localparam logic [MW-1:0] SAT_MAG = MW'(1) << (FRAC_BITS + 1);

  always_comb begin
    s3_nxt.vld   = dv_r[QW].vld;
    s3_nxt.err   = dv_r[QW].err;
    s3_nxt.mag_p = dv_r[QW].sat_p ? SAT_MAG : MW'(dv_r[QW].q_p);
    s3_nxt.mag_g = dv_r[QW].sat_g ? SAT_MAG : MW'(dv_r[QW].q_g);
    s3_nxt.pol   = dv_r[QW].neg_p ? -$signed({1'b0, s3_nxt.mag_p})
                                  : $signed({1'b0, s3_nxt.mag_p});
    s3_nxt.grd   = dv_r[QW].neg_g ? -$signed({1'b0, s3_nxt.mag_g})
                                  : $signed({1'b0, s3_nxt.mag_g});
    s3_nxt.pgneg = dv_r[QW].neg_p ^ dv_r[QW].neg_g;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_r <= '0;
    else if (adv) s3_r <= s3_nxt;
  end

  // ---------------- stage 4: ratio product ----------------
  always_comb begin
    s4_nxt.vld   = s3_r.vld;
    s4_nxt.err   = s3_r.err;
    s4_nxt.pol   = s3_r.pol;
    s4_nxt.grd   = s3_r.grd;
    s4_nxt.prod  = (2*MW)'(s3_r.mag_p) * (2*MW)'(s3_r.mag_g);
    s4_nxt.pgneg = s3_r.pgneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_r <= '0;
    else if (adv) s4_r <= s4_nxt;
  end

  // ---------------- stage 5: truncate product toward zero ----------------
  logic [PGW-1:0] pgm;
  assign pgm = s4_r.prod[2*MW-1:FRAC_BITS];

  always_comb begin
    s5_nxt.vld = s4_r.vld;
    s5_nxt.err = s4_r.err;
    s5_nxt.pol = s4_r.pol;
    s5_nxt.grd = s4_r.grd;
    s5_nxt.pg  = s4_r.pgneg ? -$signed(pgm) : $signed(pgm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_r <= '0;
    else if (adv) s5_r <= s5_nxt;
  end

  // ---------------- stage 6: coefficient products ----------------
  always_comb begin
    s6_nxt.vld     = s5_r.vld;
    s6_nxt.err     = s5_r.err;
    s6_nxt.p[CF_A] = PW'(coef[CF_A]) <<< FRAC_BITS;
    s6_nxt.p[CF_B] = PW'(coef[CF_B]) * PW'(s5_r.pol);
    s6_nxt.p[CF_C] = PW'(coef[CF_C]) * PW'(s5_r.grd);
    s6_nxt.p[CF_D] = PW'(coef[CF_D]) * PW'(s5_r.pg);
    s6_nxt.p[CF_E] = PW'(coef[CF_E]) <<< FRAC_BITS;
    s6_nxt.p[CF_F] = PW'(coef[CF_F]) * PW'(s5_r.pol);
    s6_nxt.p[CF_G] = PW'(coef[CF_G]) * PW'(s5_r.grd);
    s6_nxt.p[CF_H] = PW'(coef[CF_H]) * PW'(s5_r.pg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_r <= '0;
    else if (adv) s6_r <= s6_nxt;
  end

  // ---------------- stage 7: N and D ----------------
  always_comb begin
    s7_nxt.vld = s6_r.vld;
    s7_nxt.err = s6_r.err;
    s7_nxt.num = NW'($signed(s6_r.p[CF_A])) + NW'($signed(s6_r.p[CF_B]))
               + NW'($signed(s6_r.p[CF_C])) + NW'($signed(s6_r.p[CF_D]));
    s7_nxt.den = NW'($signed(s6_r.p[CF_E])) + NW'($signed(s6_r.p[CF_F]))
               + NW'($signed(s6_r.p[CF_G])) + NW'($signed(s6_r.p[CF_H]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s7_r <= '0;
    else if (adv) s7_r <= s7_nxt;
  end

  // ---------------- stage 8: magnitudes, divisor check ----------------
  always_comb begin
    s8_nxt.vld  = s7_r.vld;
    s8_nxt.err  = s7_r.err;
    if (s7_r.err == ST_OK && s7_r.den == '0) s8_nxt.err = ST_ZDIV;
    s8_nxt.nneg = (s7_r.num != '0) && (s7_r.num[NW-1] ^ s7_r.den[NW-1]);
    s8_nxt.nmag = s7_r.num[NW-1] ? NW'(-s7_r.num) : NW'(s7_r.num);
    s8_nxt.dmag = s7_r.den[NW-1] ? NW'(-s7_r.den) : NW'(s7_r.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s8_r <= '0;
    else if (adv) s8_r <= s8_nxt;
  end

  // ---------------- stage 9: range checks ----------------
  logic low, high;
  assign low  = (NW+3)'(s8_r.nmag) * (NW+3)'(LOW_DIV) > (NW+3)'(s8_r.dmag);
  assign high = (NW+7)'(s8_r.nmag) * (NW+7)'(HIGH_NUM) >
                (NW+7)'(s8_r.dmag) * (NW+7)'(HIGH_DEN);

  always_comb begin
    fd0_nxt     = '0;
    fd0_nxt.vld = s8_r.vld;
    if (s8_r.err != ST_OK) fd0_nxt.st = s8_r.err;
    else if (s8_r.nneg)    fd0_nxt.st = low ? ST_LOW : ST_CROP;
    else if (high)         fd0_nxt.st = ST_HIGH;
    else                   fd0_nxt.st = ST_OK;
    fd0_nxt.rem = RMW'(s8_r.nmag) * RMW'(CONC_SCALE);
    fd0_nxt.d   = s8_r.dmag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fd_r[0] <= '0;
    else if (adv) fd_r[0] <= fd0_nxt;
  end

  // ---------------- final divider: 1600*N/D, one bit per stage ----------------
  for (genvar k = 0; k < FQ; k++) begin : g_fdiv
    localparam int B = FQ - 1 - k;
    fd_t            fd_nxt;
    logic [RMW-1:0] trial;

    assign trial = RMW'(fd_r[k].d) << B;

    always_comb begin
      fd_nxt = fd_r[k];
      if (fd_r[k].rem >= trial) begin
        fd_nxt.rem  = fd_r[k].rem - trial;
        fd_nxt.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) fd_r[k+1] <= '0;
      else if (adv) fd_r[k+1] <= fd_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else if (adv) begin
      out_valid_r              <= fd_r[FQ].vld;
      out_data_r.status        <= fd_r[FQ].st;
      out_data_r.concentration <= (fd_r[FQ].st == ST_OK) ? fd_r[FQ].q : '0;
    end
  end

endmodule
`default_nettype wire
